FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Item opcodes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the operands of an accepted item
        logic exec;   // update the store and the result registers
    } t_cmd;

endpackage

FILE: rtl/core/sorted_priority_queue.sv
// Result strobe o_done is registered from the execute state after the accept.
// No new item is taken while busy (accept cycle, then an execute state in which
// every cell compares against the new value and shifts in parallel).
// busy is high during the execute cycle; the receiver cannot stall.
// Reset (synchronous, active low) empties the store; cell contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-first priority queue kept as a sorted row of cells; equal
// values leave in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_opcode,
    input  logic signed [31:0] i_item_value,
    output logic               o_done,
    output logic signed [31:0] o_out_value,
    output logic [1:0]         o_status,
    output logic               o_now_empty,
    output logic               o_now_full
);
    import spq_pkg::*;

    t_cmd cmd;

    // Sequence each transfer
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // Hold the sorted store and the result registers
    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_opcode),
        .i_item_value (i_item_value),
        .o_out_value  (o_out_value),
        .o_status     (o_status),
        .o_now_empty  (o_now_empty),
        .o_now_full   (o_now_full)
    );

endmodule

FILE: rtl/core/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: accepts one item, runs the execute state, strobes the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    output spq_pkg::t_cmd o_cmd
);
    import spq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_done;

    // Decode commands from the state
    always_comb begin
        o_cmd.load = start && (r_state == S_IDLE);
        o_cmd.exec = (r_state == S_EXEC);
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance the state and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.exec;
        end
    end

    assign busy   = (r_state == S_EXEC);
    assign o_done = r_done;

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("execute state held longer than one cycle");

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_done)
        else $error("result strobe missing after execute");

    a_load_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("accepted item did not enter execute");

endmodule

FILE: rtl/core/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: sorted row of cells with parallel compare, shift on insert/remove.
// ----------------------------------------------------------------------------
module spq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spq_pkg::t_cmd       i_cmd,
    input  logic                i_opcode,
    input  logic signed [31:0]  i_item_value,
    output logic signed [31:0]  o_out_value,
    output logic [1:0]          o_status,
    output logic                o_now_empty,
    output logic                o_now_full
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // Operand registers
    logic               r_op;
    logic signed [31:0] r_value;

    // Store: cells below the count are valid and ascending
    logic signed [31:0] r_cell [CAPACITY];
    logic signed [31:0] n_cell [CAPACITY];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CAPACITY-1:0] ge;   // new value belongs at or before this cell

    logic is_full;
    logic is_empty;
    logic do_enq;
    logic do_deq;

    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign do_enq   = i_cmd.exec && (r_op == OP_ENQ) && !is_full;
    assign do_deq   = i_cmd.exec && (r_op == OP_DEQ) && !is_empty;

    // Compare all cells against the new value and form next cell contents
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign ge[i] = (CW'(i) >= r_count) || (r_value < r_cell[i]);

        if (i == 0) begin : g_first
            always_comb begin
                n_cell[i] = r_cell[i];
                if (do_enq && ge[i]) begin
                    n_cell[i] = r_value;
                end else if (do_deq) begin
                    n_cell[i] = r_cell[i+1];
                end
            end
        end else if (i == CAPACITY - 1) begin : g_last
            always_comb begin
                n_cell[i] = r_cell[i];
                if (do_enq && ge[i]) begin
                    n_cell[i] = ge[i-1] ? r_cell[i-1] : r_value;
                end
            end
        end else begin : g_mid
            always_comb begin
                n_cell[i] = r_cell[i];
                if (do_enq && ge[i]) begin
                    n_cell[i] = ge[i-1] ? r_cell[i-1] : r_value;
                end else if (do_deq) begin
                    n_cell[i] = r_cell[i+1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[i] <= n_cell[i];
        end
    end

    // Next fill count
    always_comb begin
        n_count = r_count;
        if (do_enq) begin
            n_count = r_count + CW'(1);
        end else if (do_deq) begin
            n_count = r_count - CW'(1);
        end
    end

    // Hold operands of the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_value <= i_item_value;
        end
    end

    // Update the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Register the result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_out_value <= do_deq ? r_cell[0] : 32'sd0;
            if ((r_op == OP_ENQ) && is_full) begin
                o_status <= ST_FULL;
            end else if ((r_op == OP_DEQ) && is_empty) begin
                o_status <= ST_EMPTY;
            end else begin
                o_status <= ST_DONE;
            end
            o_now_empty <= (n_count == '0);
            o_now_full  <= (n_count == CW'(CAPACITY));
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.exec) |-> !(o_now_empty && o_now_full))
        else $error("empty and full flagged together");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_ENQ) && is_full)
            |=> (o_status == ST_FULL) && o_now_full && $stable(r_count))
        else $error("enqueue on full store not rejected cleanly");

    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_DEQ) && is_empty)
            |=> (o_status == ST_EMPTY) && o_now_empty && (o_out_value == 32'sd0))
        else $error("dequeue on empty store not rejected cleanly");

endmodule
